@@ src/macp_pkg.sv @@
// ----------------------------------------------------------------------------
// macp_pkg: shared types and constants of the MAC address text parser
// Character codes, text geometry, hex digit decode and the result item type.
// ----------------------------------------------------------------------------
package macp_pkg;

   localparam int ADDRESS_BYTES = 6;
   localparam int CHAR_W        = 8;
   localparam int VALUE_W       = 48;
   localparam int POS_W         = 5;
   localparam int NIB_W         = 4;

   // colon-separated text length, e.g. 17 for six bytes
   localparam logic [POS_W-1:0] TEXT_LENGTH = POS_W'(3 * ADDRESS_BYTES - 1);
   localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] FIRST_DELIM = POS_W'(2);

   localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_DASH   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOW_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_F   = 8'h46;
   localparam logic [CHAR_W-1:0] HEX_TEN     = 8'd10;

   // position within a byte group: two digits then a delimiter slot
   typedef enum logic [1:0] {
      PH_HI    = 2'd0,
      PH_LO    = 2'd1,
      PH_DELIM = 2'd2
   } phase_type;

   typedef struct packed {
      logic             valid;
      logic [NIB_W-1:0] nib;
   } digit_type;

   typedef struct packed {
      logic [VALUE_W-1:0] mac_address;
      logic               parse_ok;
   } result_type;

   function automatic digit_type decode_digit(input logic [CHAR_W-1:0] c);
      digit_type    d;
      logic [CHAR_W-1:0] v;
      d = '0;
      v = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = c - CHAR_ZERO;
         d.valid = 1'b1;
      end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
         v = c - CHAR_LOW_A + HEX_TEN;
         d.valid = 1'b1;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         v = c - CHAR_UP_A + HEX_TEN;
         d.valid = 1'b1;
      end
      d.nib = v[NIB_W-1:0];
      return d;
   endfunction

endpackage

@@ src/mac_address_text_parser_unit.sv @@
// Path: an accepted NUL item is held in the input register, then its result
// is registered in the result register and presented from there.
// Throughput: one character item per cycle unless a NUL waits for room downstream, set by
// the single-pass update between the input register and the result register.
// Reset: synchronous, active high; clears position, delimiter, error flag,
// assembled value and all valid flags. The state also returns to reset after each NUL.
// ----------------------------------------------------------------------------
// mac_address_text_parser_unit: MAC address text parser
// Takes ASCII characters, returns one address and ok flag per NUL-ended string.
// ----------------------------------------------------------------------------
module mac_address_text_parser_unit
   import macp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [CHAR_W-1:0]  req_tdata,   // [7:0] char_code
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [47:0] mac_address
   output logic               rsp_tuser    // [0] parse_ok
);

   logic              st_valid;
   logic              st_ready;
   logic [CHAR_W-1:0] st_char;
   logic              res_valid;
   logic              res_ready;
   result_type        res_data;
   result_type        out_data;

   macp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_char   (req_tdata),
      .out_valid (st_valid),
      .out_ready (st_ready),
      .out_char  (st_char)
   );

   macp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid),
      .in_ready  (st_ready),
      .in_char   (st_char),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   macp_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = out_data.mac_address;
   assign rsp_tuser = out_data.parse_ok;

endmodule

@@ src/macp_in_stage.sv @@
// ----------------------------------------------------------------------------
// macp_in_stage: input register
// Holds one character item; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module macp_in_stage
   import macp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CHAR_W-1:0] in_char,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CHAR_W-1:0] out_char
);

   logic              valid_ff;
   logic              valid_in;
   logic [CHAR_W-1:0] char_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_char  = char_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         char_ff <= in_char;
      end
   end

endmodule

@@ src/macp_core.sv @@
// ----------------------------------------------------------------------------
// macp_core: parser state and per-character update
// Checks digit and delimiter slots, shifts digits in, emits a result on NUL.
// ----------------------------------------------------------------------------
module macp_core
   import macp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CHAR_W-1:0] in_char,
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res_data
);

   logic [POS_W-1:0]   pos_ff,   pos_in;
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               dash_ff,  dash_in;
   logic               err_ff,   err_in;

   logic      is_nul;
   logic      is_colon;
   logic      is_dash;
   logic      take;
   digit_type digit;

   assign is_nul   = (in_char == CHAR_NUL);
   assign is_colon = (in_char == CHAR_COLON);
   assign is_dash  = (in_char == CHAR_DASH);
   assign digit    = decode_digit(in_char);

   // only a NUL needs room downstream
   assign in_ready  = !is_nul || res_ready;
   assign res_valid = in_valid && is_nul;
   assign take      = in_valid && in_ready;

   always_comb begin
      res_data.parse_ok    = !err_ff && (pos_ff == TEXT_LENGTH);
      res_data.mac_address = res_data.parse_ok ? value_ff : '0;
   end

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      value_in = value_ff;
      dash_in  = dash_ff;
      err_in   = err_ff;
      if (take) begin
         if (is_nul) begin
            pos_in   = '0;
            phase_in = PH_HI;
            value_in = '0;
            dash_in  = 1'b0;
            err_in   = 1'b0;
         end else begin
            if (pos_ff >= TEXT_LENGTH) begin
               err_in = 1'b1;
            end else if (phase_ff == PH_DELIM) begin
               if (!is_colon && !is_dash) begin
                  err_in = 1'b1;
               end else if (pos_ff == FIRST_DELIM) begin
                  dash_in = is_dash;
               end else if (is_dash != dash_ff) begin
                  err_in = 1'b1;
               end
            end else if (digit.valid) begin
               value_in = {value_ff[VALUE_W-NIB_W-1:0], digit.nib};
            end else begin
               err_in = 1'b1;
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
            unique case (phase_ff)
               PH_HI:    phase_in = PH_LO;
               PH_LO:    phase_in = PH_DELIM;
               PH_DELIM: phase_in = PH_HI;
               default:  phase_in = PH_HI;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_HI;
         value_ff <= '0;
         dash_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         value_ff <= value_in;
         dash_ff  <= dash_in;
         err_ff   <= err_in;
      end
   end

endmodule

@@ src/macp_out_skid.sv @@
// ----------------------------------------------------------------------------
// macp_out_skid: result register with skid entry
// Registered ready toward the core; holds up to two result items.
// ----------------------------------------------------------------------------
module macp_out_skid
   import macp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (in_valid && in_ready) begin
         if (main_valid_ff && !out_ready) begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end
      end else if (out_ready) begin
         main_in       = skid_ff;
         main_valid_in = skid_valid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
